// File: rtl/imab_pkg.sv
// Shared types, constants and the step-size table for the IMA ADPCM block decoder.
package imab_pkg;

    localparam int unsigned IDX_W = 7;
    localparam int unsigned STEP_W = 15;

    localparam logic [IDX_W-1:0] IDX_MAX = 7'd88;

    localparam logic signed [17:0] SUM_MAX = 18'sd32767;
    localparam logic signed [17:0] SUM_MIN = -18'sd32768;

    localparam logic [1:0] REG_WORDS_PER_BLOCK = 2'd0;
    localparam logic [1:0] REG_TOTAL_SAMPLES   = 2'd1;
    localparam logic [1:0] REG_LOOP_ENABLE     = 2'd2;

    typedef struct packed {
        logic signed [15:0] predictor;
        logic [IDX_W-1:0]   step_index;
    } imab_state_t;

    function automatic logic [STEP_W-1:0] step_size(input logic [IDX_W-1:0] idx);
        logic [STEP_W-1:0] s;
        begin
            case (idx)
                7'd0:  s = 15'd7;     7'd1:  s = 15'd8;     7'd2:  s = 15'd9;
                7'd3:  s = 15'd10;    7'd4:  s = 15'd11;    7'd5:  s = 15'd12;
                7'd6:  s = 15'd13;    7'd7:  s = 15'd14;    7'd8:  s = 15'd16;
                7'd9:  s = 15'd17;    7'd10: s = 15'd19;    7'd11: s = 15'd21;
                7'd12: s = 15'd23;    7'd13: s = 15'd25;    7'd14: s = 15'd28;
                7'd15: s = 15'd31;    7'd16: s = 15'd34;    7'd17: s = 15'd37;
                7'd18: s = 15'd41;    7'd19: s = 15'd45;    7'd20: s = 15'd50;
                7'd21: s = 15'd55;    7'd22: s = 15'd60;    7'd23: s = 15'd66;
                7'd24: s = 15'd73;    7'd25: s = 15'd80;    7'd26: s = 15'd88;
                7'd27: s = 15'd97;    7'd28: s = 15'd107;   7'd29: s = 15'd118;
                7'd30: s = 15'd130;   7'd31: s = 15'd143;   7'd32: s = 15'd157;
                7'd33: s = 15'd173;   7'd34: s = 15'd190;   7'd35: s = 15'd209;
                7'd36: s = 15'd230;   7'd37: s = 15'd253;   7'd38: s = 15'd279;
                7'd39: s = 15'd307;   7'd40: s = 15'd337;   7'd41: s = 15'd371;
                7'd42: s = 15'd408;   7'd43: s = 15'd449;   7'd44: s = 15'd494;
                7'd45: s = 15'd544;   7'd46: s = 15'd598;   7'd47: s = 15'd658;
                7'd48: s = 15'd724;   7'd49: s = 15'd796;   7'd50: s = 15'd876;
                7'd51: s = 15'd963;   7'd52: s = 15'd1060;  7'd53: s = 15'd1166;
                7'd54: s = 15'd1282;  7'd55: s = 15'd1411;  7'd56: s = 15'd1552;
                7'd57: s = 15'd1707;  7'd58: s = 15'd1878;  7'd59: s = 15'd2066;
                7'd60: s = 15'd2272;  7'd61: s = 15'd2499;  7'd62: s = 15'd2749;
                7'd63: s = 15'd3024;  7'd64: s = 15'd3327;  7'd65: s = 15'd3660;
                7'd66: s = 15'd4026;  7'd67: s = 15'd4428;  7'd68: s = 15'd4871;
                7'd69: s = 15'd5358;  7'd70: s = 15'd5894;  7'd71: s = 15'd6484;
                7'd72: s = 15'd7132;  7'd73: s = 15'd7845;  7'd74: s = 15'd8630;
                7'd75: s = 15'd9493;  7'd76: s = 15'd10442; 7'd77: s = 15'd11487;
                7'd78: s = 15'd12635; 7'd79: s = 15'd13899; 7'd80: s = 15'd15289;
                7'd81: s = 15'd16818; 7'd82: s = 15'd18500; 7'd83: s = 15'd20350;
                7'd84: s = 15'd22385; 7'd85: s = 15'd24623; 7'd86: s = 15'd27086;
                7'd87: s = 15'd29794;
                default: s = 15'd32767;
            endcase
            return s;
        end
    endfunction

endpackage

// File: rtl/imab_nibble.sv
// One IMA ADPCM nibble: predictor update with saturation and step index adaptation.
module imab_nibble (
    input  imab_pkg::imab_state_t cur,
    input  logic [3:0]            nib,
    output imab_pkg::imab_state_t nxt
);

    logic [imab_pkg::STEP_W-1:0] step;
    logic [16:0]                 delta;
    logic signed [17:0]          sum;
    logic signed [8:0]           adj;
    logic signed [8:0]           idx_sum;

    assign step = imab_pkg::step_size(cur.step_index);

    always_comb begin
        delta = {2'b00, step >> 3};
        if (nib[2]) begin
            delta = delta + {2'b00, step};
        end
        if (nib[1]) begin
            delta = delta + {2'b00, step >> 1};
        end
        if (nib[0]) begin
            delta = delta + {2'b00, step >> 2};
        end
        if (nib[3]) begin
            sum = {{2{cur.predictor[15]}}, cur.predictor} - $signed({1'b0, delta});
        end else begin
            sum = {{2{cur.predictor[15]}}, cur.predictor} + $signed({1'b0, delta});
        end
        if (sum > imab_pkg::SUM_MAX) begin
            nxt.predictor = 16'sh7fff;
        end else if (sum < imab_pkg::SUM_MIN) begin
            nxt.predictor = 16'sh8000;
        end else begin
            nxt.predictor = sum[15:0];
        end

        // Large magnitudes raise the step index by 2, 4, 6 or 8; small ones lower it by one.
        if (nib[2]) begin
            adj = $signed({5'b00000, nib[1:0] + 2'd1, 1'b0} & 9'h0ff)
                  + (nib[1:0] == 2'd3 ? 9'sd8 - 9'sd0 - $signed({5'b0, 4'd0}) - 9'sd0 : 9'sd0);
        end else begin
            adj = -9'sd1;
        end
        idx_sum = $signed({2'b00, cur.step_index}) + adj;
        if (idx_sum < 9'sd0) begin
            nxt.step_index = '0;
        end else if (idx_sum > $signed({2'b00, imab_pkg::IDX_MAX})) begin
            nxt.step_index = imab_pkg::IDX_MAX;
        end else begin
            nxt.step_index = idx_sum[6:0];
        end
    end

endmodule

// File: rtl/ima_adpcm_block_decoder_core.sv
// IMA ADPCM block decoder: word register, nibble decode step and output register. The decoder
// gives one sample per cycle while the output is not stalled. An accepted word is registered,
// and each result is registered again in the output register. A header word gives one result,
// a data word eight (fewer at a looping end), from the single step holding predictor and index.
// The next word is taken in the cycle that its predecessor's final result is produced.
// Synchronous active-low reset clears the decode state and sets the registers to 255, 0, 0.
module ima_adpcm_block_decoder_core (
    input  logic        aclk,
    input  logic        aresetn,
    // Register write port
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wdata,
    // Input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] data_word
    // Decoded samples
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [15:0] sample
    output logic        m_tuser,   // [0] past_end
    output logic        m_tlast
);

    logic [9:0]  wpb_reg;
    logic [31:0] total_reg;
    logic        loop_reg;

    logic [31:0] word_reg;
    logic        busy_reg, busy_next;
    logic [2:0]  pos_reg, pos_next;
    imab_pkg::imab_state_t st_reg, st_next;
    logic [10:0] wib_reg, wib_next;
    logic [31:0] se_reg, se_next;

    logic        out_valid_reg, out_valid_next;
    logic [15:0] out_sample_reg;
    logic        out_past_reg;
    logic        out_last_reg;

    imab_pkg::imab_state_t dec_st;
    logic [3:0]  nib;
    logic        fire, s_acc;
    logic        se_ge, is_header, is_pad, brk;
    logic [31:0] se_inc;
    logic [10:0] wib_inc;
    logic [15:0] res_sample;
    logic        res_past, res_last;

    assign nib = word_reg[{pos_reg, 2'b00} +: 4];

    imab_nibble u_nibble (
        .cur (st_reg),
        .nib (nib),
        .nxt (dec_st)
    );

    assign fire     = busy_reg && (!out_valid_reg || m_tready);
    assign s_tready = !busy_reg || (fire && res_last);
    assign s_acc    = s_tvalid && s_tready;

    assign se_ge     = se_reg >= total_reg;
    assign se_inc    = se_reg + 32'd1;
    assign wib_inc   = wib_reg + 11'd1;
    assign is_header = (pos_reg == 3'd0) && ((wib_reg == 11'd0) || (se_ge && loop_reg));
    assign is_pad    = !is_header && se_ge;
    // Looping end found after this sample: the rest of the word is dropped here.
    assign brk       = loop_reg && (se_inc >= total_reg) && (pos_reg != 3'd7);

    always_comb begin
        st_next  = st_reg;
        wib_next = wib_reg;
        se_next  = se_reg;
        if (is_header) begin
            res_sample           = word_reg[15:0];
            res_past             = 1'b0;
            res_last             = 1'b1;
            st_next.predictor    = word_reg[15:0];
            st_next.step_index   = (word_reg[23:16] > {1'b0, imab_pkg::IDX_MAX})
                                   ? imab_pkg::IDX_MAX : word_reg[22:16];
            wib_next             = 11'd1;
            // A looping restart clears the sample count before the header counts itself.
            se_next              = (wib_reg == 11'd0) ? se_inc : 32'd1;
        end else if (is_pad) begin
            res_sample = '0;
            res_past   = 1'b1;
            res_last   = (pos_reg == 3'd7);
        end else begin
            res_sample = dec_st.predictor;
            res_past   = 1'b0;
            res_last   = (pos_reg == 3'd7) || brk;
            st_next    = dec_st;
            se_next    = se_inc;
            if (pos_reg == 3'd7) begin
                wib_next = (wib_inc > {1'b0, wpb_reg}) ? 11'd0 : wib_inc;
            end
            if (brk) begin
                st_next  = '0;
                wib_next = '0;
                se_next  = '0;
            end
        end
    end

    always_comb begin
        busy_next = busy_reg;
        pos_next  = pos_reg;
        if (fire) begin
            pos_next = res_last ? 3'd0 : pos_reg + 3'd1;
            if (res_last) begin
                busy_next = 1'b0;
            end
        end
        if (s_acc) begin
            busy_next = 1'b1;
            pos_next  = 3'd0;
        end
        out_valid_next = fire || (out_valid_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wpb_reg       <= 10'd255;
            total_reg     <= '0;
            loop_reg      <= 1'b0;
            busy_reg      <= 1'b0;
            pos_reg       <= '0;
            st_reg        <= '0;
            wib_reg       <= '0;
            se_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    imab_pkg::REG_WORDS_PER_BLOCK: wpb_reg   <= cfg_wdata[9:0];
                    imab_pkg::REG_TOTAL_SAMPLES:   total_reg <= cfg_wdata;
                    imab_pkg::REG_LOOP_ENABLE:     loop_reg  <= cfg_wdata[0];
                    default: ;
                endcase
            end
            busy_reg      <= busy_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
            if (fire) begin
                st_reg  <= st_next;
                wib_reg <= wib_next;
                se_reg  <= se_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            word_reg <= s_tdata;
        end
        if (fire) begin
            out_sample_reg <= res_sample;
            out_past_reg   <= res_past;
            out_last_reg   <= res_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_sample_reg;
    assign m_tuser  = out_past_reg;
    assign m_tlast  = out_last_reg;

    a_pad_is_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == 16'd0)
        else $error("padding beat carries a non-zero sample");

    a_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        st_reg.step_index <= imab_pkg::IDX_MAX)
        else $error("step index beyond table");

    a_idle_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        !busy_reg |-> pos_reg == 3'd0)
        else $error("nibble position not cleared while idle");

    a_word_done: assert property (@(posedge aclk) disable iff (!aresetn)
        fire && res_last && !s_tvalid |=> !busy_reg)
        else $error("decoder stayed busy after final result of a word");

endmodule
